@@ design/led_pwm_frame_store_shift_out_core_macros.svh @@
// ----------------------------------------------------------------------------
// LED PWM frame store assertion macros
// Short forms for clocked assertions that are disabled while in reset.
// They expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LED_PWM_FRAME_STORE_SHIFT_OUT_CORE_MACROS_SVH
`define LED_PWM_FRAME_STORE_SHIFT_OUT_CORE_MACROS_SVH

// Check a property at every rising edge outside reset.
`define LPFS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition is followed, in the next cycle, by another.
`define LPFS_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

@@ design/lpfs_pkg.sv @@
// ----------------------------------------------------------------------------
// LED PWM frame store package
// Shared constants, action codes, the command word and the gradient order table.
// ----------------------------------------------------------------------------
package lpfs_pkg;

	localparam int NUM_CHIPS_DEF     = 4;
	localparam int CHANNELS_PER_CHIP = 24;
	localparam int LEVEL_BITS        = 12;
	localparam int CHIP_W            = 2;
	localparam int CH_W              = 5;
	localparam int ROW_W             = 4;
	localparam int VALUE_W           = 16;
	localparam int GRAD_R_W          = 3;
	localparam int ROWS_PER_PAIR     = 6;
	localparam int CMD_FIFO_DEPTH    = 2;
	localparam int S_TDATA_W         = 32;
	localparam int S_TUSER_W         = 2;
	localparam int M_TDATA_W         = 16;

	localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};

	localparam logic [1:0] ACT_SET_CHANNEL  = 2'd0;
	localparam logic [1:0] ACT_SET_ALL      = 2'd1;
	localparam logic [1:0] ACT_SET_GRADIENT = 2'd2;
	localparam logic [1:0] ACT_FLUSH        = 2'd3;

	// For a gradient command, chip holds the chip pair and grad_r the row within it.
	typedef struct packed {
		logic [1:0]            act;
		logic [CHIP_W-1:0]     chip;
		logic [CH_W-1:0]       channel;
		logic [GRAD_R_W-1:0]   grad_r;
		logic [LEVEL_BITS-1:0] level;
	} cmd_t;

	// Channel written at position o of gradient order row r.
	function automatic logic [CH_W-1:0] order_chan(input logic [GRAD_R_W-1:0] r,
			input logic [1:0] o);
		logic [4*CH_W-1:0] row_bits;
		case (r)
			3'd0:    row_bits = {5'd5, 5'd4, 5'd3, 5'd2};
			3'd1:    row_bits = {5'd8, 5'd7, 5'd6, 5'd1};
			3'd2:    row_bits = {5'd11, 5'd10, 5'd9, 5'd0};
			3'd3:    row_bits = {5'd12, 5'd13, 5'd14, 5'd23};
			3'd4:    row_bits = {5'd15, 5'd16, 5'd17, 5'd22};
			3'd5:    row_bits = {5'd18, 5'd19, 5'd20, 5'd21};
			default: row_bits = '0;
		endcase
		return row_bits[o*CH_W +: CH_W];
	endfunction

endpackage

@@ design/lpfs_front.sv @@
// ----------------------------------------------------------------------------
// LED PWM frame store front end
// Unpack an input word, saturate the level, drop actions that touch nothing
// and hand the rest on as a command.
// ----------------------------------------------------------------------------
module lpfs_front #(
	parameter int NUM_CHIPS = lpfs_pkg::NUM_CHIPS_DEF
) (
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lpfs_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [lpfs_pkg::S_TUSER_W-1:0] s_tuser,
	input  logic                           q_full,
	input  logic                           clearing,
	output logic                           push,
	output lpfs_pkg::cmd_t                 push_cmd
);
	import lpfs_pkg::*;

	localparam logic [4:0] NC = 5'(NUM_CHIPS);

	logic [1:0]            act;
	logic [CHIP_W-1:0]     chip;
	logic [CH_W-1:0]       channel;
	logic [ROW_W-1:0]      row;
	logic [VALUE_W-1:0]    value;
	logic [LEVEL_BITS-1:0] level;
	logic [1:0]            pair;
	logic [ROW_W-1:0]      pair_base;
	logic                  chip_ok;
	logic                  keep;

	assign act     = s_tuser;
	assign chip    = s_tdata[1:0];
	assign channel = s_tdata[6:2];
	assign row     = s_tdata[10:7];
	assign value   = s_tdata[26:11];

	// Saturate to full scale.
	assign level = (value[VALUE_W-1:LEVEL_BITS] != '0) ? LEVEL_MAX : value[LEVEL_BITS-1:0];

	// Row to chip pair and row within the pair.
	assign pair      = (row >= 4'd12) ? 2'd2 : ((row >= 4'(ROWS_PER_PAIR)) ? 2'd1 : 2'd0);
	assign pair_base = {2'b00, pair} * 4'(ROWS_PER_PAIR);
	assign chip_ok   = {3'b000, chip} < NC;

	always_comb begin
		unique case (act)
			ACT_SET_CHANNEL:  keep = chip_ok && (channel < CH_W'(CHANNELS_PER_CHIP));
			ACT_SET_ALL:      keep = 1'b1;
			ACT_SET_GRADIENT: keep = {2'b00, pair, 1'b1} < NC;
			ACT_FLUSH:        keep = chip_ok;
			default:          keep = 1'b0;
		endcase
	end

	always_comb begin
		push_cmd.act     = act;
		push_cmd.chip    = (act == ACT_SET_GRADIENT) ? pair : chip;
		push_cmd.channel = channel;
		push_cmd.grad_r  = GRAD_R_W'(row - pair_base);
		push_cmd.level   = level;
	end

	assign s_tready = !q_full && !clearing;
	assign push     = s_tvalid && s_tready && keep;

endmodule

@@ design/lpfs_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// LED PWM frame store command queue
// Short queue of commands between the front end and the store sequencer.
// ----------------------------------------------------------------------------
module lpfs_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lpfs_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           valid,
	output lpfs_pkg::cmd_t head,
	input  logic           pop
);
	import lpfs_pkg::*;

	localparam int DEPTH = CMD_FIFO_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CNT_W'(DEPTH);
	assign valid   = count_q != '0;
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ design/lpfs_back.sv @@
// ----------------------------------------------------------------------------
// LED PWM frame store back end
// Level memory with its sequencer: clearing pass, single writes, fill sweep,
// gradient writes and chip read-out through a registered output stage.
// ----------------------------------------------------------------------------
`include "led_pwm_frame_store_shift_out_core_macros.svh"

module lpfs_back #(
	parameter int NUM_CHIPS = lpfs_pkg::NUM_CHIPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  lpfs_pkg::cmd_t                 q_cmd,
	output logic                           q_pop,
	output logic                           clearing,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lpfs_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast
);
	import lpfs_pkg::*;

	localparam int DEPTH  = NUM_CHIPS * CHANNELS_PER_CHIP;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [CH_W-1:0]   LAST_CH   = CH_W'(CHANNELS_PER_CHIP - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_FILL  = 3'd2;
	localparam logic [2:0] ST_GRAD  = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [LEVEL_BITS-1:0] level_mem [DEPTH];

	logic [2:0]            state_q, state_d;
	logic [ADDR_W-1:0]     cnt_q, cnt_d;
	logic [LEVEL_BITS-1:0] lvl_q;
	logic [CHIP_W-1:0]     chip_q;
	logic [GRAD_R_W-1:0]   grad_r_q;

	logic                  mem_we;
	logic                  rd_issue;
	logic                  use_cnt_addr;
	logic [2:0]            chip_sel;
	logic [CH_W-1:0]       chan_sel;
	logic [LEVEL_BITS-1:0] wdata;
	logic [ADDR_W-1:0]     addr;
	logic [GRAD_R_W-1:0]   grad_rsel;
	logic                  flush_last;

	logic                  rd_valid_s1;
	logic [CHIP_W-1:0]     rd_chip_s1;
	logic                  rd_last_s1;
	logic [LEVEL_BITS-1:0] rdata_s1;
	logic                  rd_move;
	logic                  rd_room;

	logic                  out_valid_q;
	logic [CHIP_W-1:0]     out_chip_q;
	logic [LEVEL_BITS-1:0] out_word_q;
	logic                  out_last_q;

	assign clearing   = state_q == ST_CLEAR;
	assign flush_last = cnt_q[CH_W-1:0] == LAST_CH;
	// Odd chip of the pair takes the mirrored order row.
	assign grad_rsel  = cnt_q[2] ? GRAD_R_W'(ROWS_PER_PAIR - 1) - grad_r_q : grad_r_q;

	assign rd_move = rd_valid_s1 && (!out_valid_q || m_tready);
	assign rd_room = !rd_valid_s1 || rd_move;

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		q_pop        = 1'b0;
		mem_we       = 1'b0;
		rd_issue     = 1'b0;
		use_cnt_addr = 1'b0;
		chip_sel     = '0;
		chan_sel     = '0;
		wdata        = lvl_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we       = 1'b1;
				use_cnt_addr = 1'b1;
				wdata        = '0;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == LAST_ADDR) begin
					state_d = ST_IDLE;
					cnt_d   = '0;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_cmd.act)
						ACT_SET_CHANNEL: begin
							mem_we   = 1'b1;
							chip_sel = {1'b0, q_cmd.chip};
							chan_sel = q_cmd.channel;
							wdata    = q_cmd.level;
						end
						ACT_SET_ALL:      state_d = ST_FILL;
						ACT_SET_GRADIENT: state_d = ST_GRAD;
						ACT_FLUSH:        state_d = ST_FLUSH;
						default:          state_d = ST_IDLE;
					endcase
				end
			end
			ST_FILL: begin
				mem_we       = 1'b1;
				use_cnt_addr = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == LAST_ADDR) begin
					state_d = ST_IDLE;
					cnt_d   = '0;
				end
			end
			ST_GRAD: begin
				mem_we   = 1'b1;
				chip_sel = {chip_q, cnt_q[2]};
				chan_sel = order_chan(grad_rsel, cnt_q[1:0]);
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q[2:0] == 3'd7) begin
					state_d = ST_IDLE;
					cnt_d   = '0;
				end
			end
			ST_FLUSH: begin
				chip_sel = {1'b0, chip_q};
				chan_sel = LAST_CH - cnt_q[CH_W-1:0];
				if (rd_room) begin
					rd_issue = 1'b1;
					cnt_d    = cnt_q + 1'b1;
					if (flush_last) begin
						state_d = ST_IDLE;
						cnt_d   = '0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	assign addr = use_cnt_addr ? cnt_q
		: ADDR_W'(chip_sel * CHANNELS_PER_CHIP) + ADDR_W'(chan_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (rd_issue) begin
				rd_valid_s1 <= 1'b1;
			end else if (rd_move) begin
				rd_valid_s1 <= 1'b0;
			end
			if (rd_move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command operands, level memory, read stage and output payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			lvl_q    <= q_cmd.level;
			chip_q   <= q_cmd.chip;
			grad_r_q <= q_cmd.grad_r;
		end
		if (mem_we) begin
			level_mem[addr] <= wdata;
		end
		if (rd_issue) begin
			rdata_s1   <= level_mem[addr];
			rd_chip_s1 <= chip_q;
			rd_last_s1 <= flush_last;
		end
		if (rd_move) begin
			out_chip_q <= rd_chip_s1;
			out_word_q <= rdata_s1;
			out_last_q <= rd_last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W - LEVEL_BITS - CHIP_W){1'b0}}, out_word_q, out_chip_q};
	assign m_tlast  = out_last_q;

	`LPFS_ASSERT(a_no_rw_clash, !(mem_we && rd_issue), "store written and read in one cycle")
	`LPFS_ASSERT(a_pop_only_idle, q_pop |-> state_q == ST_IDLE, "command taken while busy")
	`LPFS_ASSERT_NEXT(a_flush_ends, state_q == ST_FLUSH && rd_issue && flush_last, state_q == ST_IDLE, "flush did not end after its last word")
	`LPFS_ASSERT_NEXT(a_rd_hold, rd_valid_s1 && !rd_move, rd_valid_s1 && $stable(rdata_s1), "stalled read word lost")

endmodule

@@ design/led_pwm_frame_store_shift_out_core.sv @@
// ----------------------------------------------------------------------------
// LED PWM frame store and shift-out core
// Store of 12-bit PWM levels for a daisy chain of LED driver chips, written
// by host actions and read out one chip at a time as a word stream.
//
//   channel  dir  tdata (low bit up)                         tuser / tlast
//   s_       in   chip[1:0] channel[6:2] row[10:7]           tuser: action
//                 value[26:11], zero to 31
//   m_       out  out_chip[1:0] pwm_word[13:2], zero to 15   tlast: latch
//
// Commands: the sequencer takes each command from the queue when idle
// (set-channel writes as it is taken); set-gradient-row then adds 8 writes,
// set-all NUM_CHIPS*24 writes (one entry per cycle of the single write port),
// flush 24 reads at one word per cycle while m_tready stays high; the first
// word passes the read stage and the output register on its way to m_.
// Reset: a clearing pass zeroes all NUM_CHIPS*24 entries of the level memory;
// s_tready stays low until it ends.
// Stalls: a two-entry command queue lets the input side run ahead of the
// sequencer; a stalled m_ side holds the read-out, the read stage and the
// output register each keep one word.
// ----------------------------------------------------------------------------
module led_pwm_frame_store_shift_out_core #(
	parameter int NUM_CHIPS = lpfs_pkg::NUM_CHIPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// chip, channel, row, value
	input  logic [lpfs_pkg::S_TDATA_W-1:0] s_tdata,
	// action
	input  logic [lpfs_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_chip, pwm_word
	output logic [lpfs_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                           m_tlast
);
	import lpfs_pkg::*;

	logic q_full;
	logic q_valid;
	logic q_pop;
	logic push;
	logic clearing;
	cmd_t push_cmd;
	cmd_t q_head;

	// Decode and filter incoming words.
	lpfs_front #(
		.NUM_CHIPS(NUM_CHIPS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.clearing (clearing),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Buffer commands between the two halves.
	lpfs_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.valid    (q_valid),
		.head     (q_head),
		.pop      (q_pop)
	);

	// Carry out writes and read-outs against the level memory.
	lpfs_back #(
		.NUM_CHIPS(NUM_CHIPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_head),
		.q_pop    (q_pop),
		.clearing (clearing),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
